// File: rtl/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

	// Side length of the square tile in pixels; coordinates are held in COORD_W bits.
	localparam int TILE_SIZE = 64;
	localparam int COORD_W   = 6;
	localparam int COLOR_W   = 32;

	localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // register a new line request
		logic setup;     // order the endpoints and load the walk registers
		logic advance;   // current pixel taken, step to the next one
	} lpg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;      // the walk sits on the final pixel of the line
	} lpg_status_t;

	// Saturate a coordinate to the tile.
	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] r;
		r = v;
		if (v > TILE_MAX) begin
			r = TILE_MAX;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lpg_datapath.sv
`default_nettype none

module lpg_datapath (
	input  wire logic                        clk,
	input  wire lpg_pkg::lpg_cmd_t           cmd,
	output lpg_pkg::lpg_status_t             status,
	input  wire logic [lpg_pkg::COORD_W-1:0] x_start,
	input  wire logic [lpg_pkg::COORD_W-1:0] y_start,
	input  wire logic [lpg_pkg::COORD_W-1:0] x_end,
	input  wire logic [lpg_pkg::COORD_W-1:0] y_end,
	input  wire logic [lpg_pkg::COLOR_W-1:0] line_color,
	output logic      [lpg_pkg::COORD_W-1:0] pixel_x,
	output logic      [lpg_pkg::COORD_W-1:0] pixel_y,
	output logic      [lpg_pkg::COLOR_W-1:0] pixel_color
);

	localparam int CW = lpg_pkg::COORD_W;

	// Captured request.
	logic [CW-1:0]              ax_q, ay_q, bx_q, by_q;
	logic [lpg_pkg::COLOR_W-1:0] color_q;

	// Walk registers.
	logic          steep_q;
	logic [CW-1:0] major_pos_q;
	logic [CW-1:0] major_stop_q;
	logic [CW-1:0] minor_pos_q;
	logic          minor_dir_down_q;
	logic [CW-1:0] major_span_q;
	logic [CW:0]   minor_span_twice_q;
	logic [CW+2:0] error_q;

	// Setup logic.
	logic [CW-1:0] adx, ady, ma0, mi0, ma1, mi1;
	logic [CW-1:0] o_ma0, o_mi0, o_ma1, o_mi1, dmin;
	logic          steep, swap;

	always_comb begin
		adx   = (bx_q > ax_q) ? (bx_q - ax_q) : (ax_q - bx_q);
		ady   = (by_q > ay_q) ? (by_q - ay_q) : (ay_q - by_q);
		steep = adx < ady;
		ma0   = steep ? ay_q : ax_q;
		mi0   = steep ? ax_q : ay_q;
		ma1   = steep ? by_q : bx_q;
		mi1   = steep ? bx_q : by_q;
		swap  = ma1 < ma0;
		o_ma0 = swap ? ma1 : ma0;
		o_mi0 = swap ? mi1 : mi0;
		o_ma1 = swap ? ma0 : ma1;
		o_mi1 = swap ? mi0 : mi1;
		dmin  = (o_mi1 > o_mi0) ? (o_mi1 - o_mi0) : (o_mi0 - o_mi1);
	end

	// Error step: gain twice the minor span, and if that passes the major
	// span, move the minor coordinate and lose twice the major span.
	logic [CW+3:0] err_sum, err_next, span_ext, span_twice_ext;
	logic          minor_step;

	always_comb begin
		err_sum        = {error_q[CW+2], error_q} + {3'b000, minor_span_twice_q};
		span_ext       = {4'b0000, major_span_q};
		span_twice_ext = {3'b000, major_span_q, 1'b0};
		minor_step     = $signed(err_sum) > $signed(span_ext);
		err_next       = minor_step ? (err_sum - span_twice_ext) : err_sum;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q    <= lpg_pkg::clamp_coord(x_start);
			ay_q    <= lpg_pkg::clamp_coord(y_start);
			bx_q    <= lpg_pkg::clamp_coord(x_end);
			by_q    <= lpg_pkg::clamp_coord(y_end);
			color_q <= line_color;
		end
		if (cmd.setup) begin
			steep_q            <= steep;
			major_pos_q        <= o_ma0;
			major_stop_q       <= o_ma1;
			minor_pos_q        <= o_mi0;
			minor_dir_down_q   <= !(o_mi1 > o_mi0);
			major_span_q       <= o_ma1 - o_ma0;
			minor_span_twice_q <= {dmin, 1'b0};
			error_q            <= '0;
		end else if (cmd.advance) begin
			major_pos_q <= major_pos_q + CW'(1);
			error_q     <= err_next[CW+2:0];
			if (minor_step) begin
				minor_pos_q <= minor_dir_down_q ? (minor_pos_q - CW'(1))
				                                : (minor_pos_q + CW'(1));
			end
		end
	end

	assign status.last = (major_pos_q == major_stop_q);
	assign pixel_x     = steep_q ? minor_pos_q : major_pos_q;
	assign pixel_y     = steep_q ? major_pos_q : minor_pos_q;
	assign pixel_color = color_q;

endmodule

`default_nettype wire

// File: rtl/lpg_ctrl.sv
`default_nettype none

module lpg_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output lpg_pkg::lpg_cmd_t         cmd,
	input  wire lpg_pkg::lpg_status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_WALK  = 3'b100
	} state_t;

	state_t state_q, state_next;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_next = ST_WALK;
			end
			ST_WALK: begin
				if (out_ready && status.last) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_WALK);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.setup   = (state_q == ST_SETUP);
	assign cmd.advance = out_valid && out_ready;

	a_capture_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.setup)
		else $error("request capture not followed by setup");

	a_setup_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup |=> out_valid && !in_ready)
		else $error("setup not followed by the pixel walk");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance && status.last |=> in_ready && !out_valid)
		else $error("final pixel taken but block not idle");

	a_walk_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status.last |=> out_valid)
		else $error("walk ended before the final pixel");

endmodule

`default_nettype wire

// File: rtl/line_pixel_generator.sv
`default_nettype none

// Line rasterizer for one 64 by 64 tile. A request carries two endpoints and
// a packed RGBA color; the block answers with every pixel of the line in walk
// order, one result per pixel, each with the request's color, and sets
// last_pixel on the final one. Lines steeper than 45 degrees are walked along
// y, others along x, always toward the larger major coordinate, with an
// integer error term stepping the minor coordinate. The request is captured at
// the accepting edge; the setup state then orders the endpoints and loads the
// walk registers, and the walk counter gives one pixel per cycle while
// out_ready stays high. Requests are handled one at a time; in_ready rises
// again in the cycle after the final pixel is taken.
module line_pixel_generator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [lpg_pkg::COORD_W-1:0] x_start,
	input  wire logic [lpg_pkg::COORD_W-1:0] y_start,
	input  wire logic [lpg_pkg::COORD_W-1:0] x_end,
	input  wire logic [lpg_pkg::COORD_W-1:0] y_end,
	input  wire logic [lpg_pkg::COLOR_W-1:0] line_color,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [lpg_pkg::COORD_W-1:0] pixel_x,
	output logic      [lpg_pkg::COORD_W-1:0] pixel_y,
	output logic      [lpg_pkg::COLOR_W-1:0] pixel_color,
	output logic                             last_pixel
);

	// Commands and status between the controller and the datapath.
	lpg_pkg::lpg_cmd_t    cmd;
	lpg_pkg::lpg_status_t status;

	// The controller sequences capture, setup and the pixel walk, and owns
	// both handshakes.
	lpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// The datapath holds the request and the walk registers; the pixel
	// outputs come straight from those registers.
	lpg_datapath u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.line_color  (line_color),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color)
	);

	// The final pixel is the one where the major coordinate reaches its end.
	assign last_pixel = status.last;

endmodule

`default_nettype wire
